// File: rtl/core/esnf_pkg.sv
// Package for the eventual safe node finder: types, constants and codes.
package esnf_pkg;

  localparam int unsigned MaxNodesDef = 64;
  localparam int unsigned NodeW = 6;
  localparam int unsigned CountW = 7;
  localparam logic [CountW-1:0] CountReset = 7'd64;

  typedef enum logic [1:0] {
    CmdAddEdge = 2'd0,
    CmdRun     = 2'd1,
    CmdClear   = 2'd2,
    CmdUnused  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [NodeW-1:0] edge_from;
    logic [NodeW-1:0] edge_to;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] safe_node;
    logic             valid_res;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StRoot,
    StRead,
    StScan,
    StMark,
    StEmit,
    StNone
  } state_e;

  // Request from the controller to the adjacency memory.
  typedef struct packed {
    logic             we;
    logic [NodeW-1:0] waddr;
    logic [63:0]      wdata;
    logic             re;
    logic [NodeW-1:0] raddr;
  } adj_req_t;

endpackage

// File: rtl/core/esnf_adj_mem.sv
// Adjacency row memory: one row per node, one write and one registered read a cycle.
module esnf_adj_mem #(
  parameter int unsigned MaxNodes = esnf_pkg::MaxNodesDef
) (
  input  logic              clk_i,
  input  esnf_pkg::adj_req_t req_i,
  output logic [63:0]       rdata_o
);
  import esnf_pkg::*;

  logic [63:0] mem_q [MaxNodes];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[$clog2(MaxNodes)-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[$clog2(MaxNodes)-1:0]];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/core/esnf_stack_mem.sv
// Walk stack memory: node and scan cursor per depth, registered read.
module esnf_stack_mem #(
  parameter int unsigned MaxNodes = esnf_pkg::MaxNodesDef
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(MaxNodes)-1:0]   waddr_i,
  input  logic [esnf_pkg::NodeW-1:0]    wnode_i,
  input  logic [esnf_pkg::CountW-1:0]   wcur_i,
  input  logic [$clog2(MaxNodes)-1:0]   raddr_i,
  output logic [esnf_pkg::NodeW-1:0]    rnode_o,
  output logic [esnf_pkg::CountW-1:0]   rcur_o
);
  import esnf_pkg::*;

  logic [NodeW+CountW-1:0] mem_q [MaxNodes];
  logic [NodeW+CountW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wnode_i, wcur_i};
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rnode_o = rd_q[NodeW+CountW-1:CountW];
  assign rcur_o  = rd_q[CountW-1:0];
endmodule

// File: rtl/core/eventual_safe_node_finder.sv
// Top level of the eventual safe node finder: command decode, walk sequencer, result emit.
//
//   channel   direction  ports                          handshake
//   command   in         start_i, in_item_i, busy_o     start_i & !busy_o
//   result    out        res_strobe_o, res_item_o        a strobe per item
//   config    in         cfg_we_i, cfg_wdata_i           write when cfg_we_i
//
// Add edge reads the row, then modifies and writes it; clear sweeps one row a cycle
// over all MAX_NODES rows. A run reads one adjacency row per push and a stack entry
// plus a row per pop, and scans one column per cycle between them; a cycle found
// marks the path by reading each stack entry below the top. Emission scans one node
// per cycle, and rescans each safe node after the one before it is released.
// Reset clears the matrix by a sweep of all MAX_NODES rows with busy_o high.
// The receiver cannot stall; results never leave back to back.
module eventual_safe_node_finder #(
  parameter int unsigned MaxNodes = esnf_pkg::MaxNodesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  esnf_pkg::in_item_t         in_item_i,
  output logic                       busy_o,
  output logic                       res_strobe_o,
  output esnf_pkg::out_item_t        res_item_o,
  input  logic                       cfg_we_i,
  input  logic [esnf_pkg::CountW-1:0] cfg_wdata_i
);
  import esnf_pkg::*;

  localparam int unsigned AW = $clog2(MaxNodes);
  localparam logic [CountW-1:0] MaxCnt = CountW'(MaxNodes);

  state_e st_q, st_d;
  logic [CountW-1:0] count_q, cnt;
  logic [63:0] vis_q, vis_d, onp_q, onp_d, uns_q, uns_d;
  logic [CountW-1:0] dep_q, dep_d;     // stack depth
  logic [CountW-1:0] i_q, i_d;         // root, clear and emit index
  logic [CountW-1:0] j_q, j_d;         // scan cursor; stack index while marking
  logic [NodeW-1:0] n_q, n_d;          // node on top
  logic [63:0] row_q, row_d;
  logic [1:0] ph_q, ph_d;              // sub-phase
  logic [NodeW-1:0] ef_q, ef_d, et_q, et_d;
  logic any_q, any_d;
  logic adding_q, adding_d;

  adj_req_t req;
  logic [63:0] rdata;
  logic sk_we;
  logic [AW-1:0] sk_wa, sk_ra;
  logic [NodeW-1:0] sk_wn, sk_rn;
  logic [CountW-1:0] sk_wc, sk_rc;
  logic strobe_d;
  out_item_t res_d, res_q;
  logic strobe_q;

  assign cnt = (count_q > MaxCnt) ? MaxCnt : count_q;

  esnf_adj_mem #(.MaxNodes(MaxNodes)) u_adj (
    .clk_i(clk_i), .req_i(req), .rdata_o(rdata)
  );

  esnf_stack_mem #(.MaxNodes(MaxNodes)) u_stk (
    .clk_i(clk_i), .we_i(sk_we), .waddr_i(sk_wa), .wnode_i(sk_wn), .wcur_i(sk_wc),
    .raddr_i(sk_ra), .rnode_o(sk_rn), .rcur_o(sk_rc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; count_q <= CountReset; vis_q <= '0; onp_q <= '0; uns_q <= '0;
      dep_q <= '0; i_q <= '0; j_q <= '0; n_q <= '0; ph_q <= '0; any_q <= 1'b0;
      adding_q <= 1'b0; strobe_q <= 1'b0;
    end else begin
      st_q <= st_d; vis_q <= vis_d; onp_q <= onp_d; uns_q <= uns_d; dep_q <= dep_d;
      i_q <= i_d; j_q <= j_d; n_q <= n_d; ph_q <= ph_d; any_q <= any_d;
      adding_q <= adding_d; strobe_q <= strobe_d;
      if (cfg_we_i) count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d; ef_q <= ef_d; et_q <= et_d; res_q <= res_d;
  end

  always_comb begin
    logic [CountW-1:0] top;
    logic hit;
    top = dep_q - 1'b1;
    hit = 1'b0;
    st_d = st_q; vis_d = vis_q; onp_d = onp_q; uns_d = uns_q; dep_d = dep_q;
    i_d = i_q; j_d = j_q; n_d = n_q; row_d = row_q; ph_d = ph_q; any_d = any_q;
    ef_d = ef_q; et_d = et_q; adding_d = adding_q;
    req = '0;
    sk_we = 1'b0; sk_wa = top[AW-1:0]; sk_wn = n_q; sk_wc = j_q; sk_ra = top[AW-1:0];
    strobe_d = 1'b0; res_d = res_q;
    busy_o = (st_q != StIdle);
    case (st_q)
      StIdle: begin
        if (start_i) begin
          ef_d = in_item_i.edge_from; et_d = in_item_i.edge_to;
          case (cmd_e'(in_item_i.command))
            CmdAddEdge: begin
              if ({1'b0, in_item_i.edge_from} < cnt && {1'b0, in_item_i.edge_to} < cnt) begin
                req.re = 1'b1; req.raddr = in_item_i.edge_from;
                adding_d = 1'b1; ph_d = 2'd0; st_d = StRead;
              end
            end
            CmdRun: begin
              vis_d = '0; onp_d = '0; uns_d = '0; dep_d = '0; i_d = '0; st_d = StRoot;
            end
            CmdClear: begin
              i_d = '0; st_d = StClear;
            end
            default: ;
          endcase
        end
      end
      StClear: begin
        req.we = 1'b1; req.waddr = i_q[NodeW-1:0]; req.wdata = '0;
        i_d = i_q + 1'b1;
        if (i_q == MaxCnt - 1'b1) st_d = StIdle;
      end
      StRoot: begin
        if (i_q >= cnt) begin
          i_d = '0; any_d = 1'b0; st_d = StEmit;
        end else if (vis_q[i_q[NodeW-1:0]]) begin
          i_d = i_q + 1'b1;
        end else begin
          vis_d[i_q[NodeW-1:0]] = 1'b1; onp_d[i_q[NodeW-1:0]] = 1'b1;
          n_d = i_q[NodeW-1:0]; j_d = '0; dep_d = 7'd1;
          req.re = 1'b1; req.raddr = i_q[NodeW-1:0];
          ph_d = 2'd1; st_d = StRead;
        end
      end
      StRead: begin
        // ph 0: add edge data; ph 1: row read in flight; ph 2: stack read in flight
        if (adding_q) begin
          req.we = 1'b1; req.waddr = ef_q;
          req.wdata = rdata | (64'd1 << et_q);
          adding_d = 1'b0; st_d = StIdle;
        end else if (ph_q == 2'd2) begin
          n_d = sk_rn; j_d = sk_rc;
          req.re = 1'b1; req.raddr = sk_rn; ph_d = 2'd1;
        end else begin
          row_d = rdata; st_d = StScan;
        end
      end
      StScan: begin
        if (j_q >= cnt) begin
          onp_d[n_q] = 1'b0; dep_d = dep_q - 1'b1;
          if (dep_q == 7'd1) begin
            i_d = i_q + 1'b1; st_d = StRoot;
          end else begin
            sk_ra = AW'(dep_q - 7'd2); ph_d = 2'd2; st_d = StRead;
          end
        end else if (!row_q[j_q[NodeW-1:0]]) begin
          j_d = j_q + 1'b1;
        end else if (!vis_q[j_q[NodeW-1:0]]) begin
          // Save the resume cursor, push the child if the stack has room.
          sk_we = 1'b1; sk_wa = top[AW-1:0]; sk_wn = n_q; sk_wc = j_q + 1'b1;
          if (dep_q < MaxCnt) begin
            vis_d[j_q[NodeW-1:0]] = 1'b1; onp_d[j_q[NodeW-1:0]] = 1'b1;
            dep_d = dep_q + 1'b1; n_d = j_q[NodeW-1:0]; j_d = '0;
            req.re = 1'b1; req.raddr = j_q[NodeW-1:0]; ph_d = 2'd1; st_d = StRead;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          hit = onp_q[j_q[NodeW-1:0]] | uns_q[j_q[NodeW-1:0]];
          if (hit) begin
            uns_d[j_q[NodeW-1:0]] = 1'b1; uns_d[n_q] = 1'b1;
            i_d = i_q; j_d = 7'd0; ph_d = 2'd0; st_d = StMark;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      StMark: begin
        // Walk stack entries below the top (the top node is already marked).
        // ph 0 issue read of entry j, ph 1 mark and advance.
        if (ph_q == 2'd0) begin
          if (j_q + 1'b1 >= dep_q) begin
            dep_d = '0; onp_d = '0; i_d = i_q + 1'b1; st_d = StRoot;
          end else begin
            sk_ra = j_q[AW-1:0]; ph_d = 2'd1;
          end
        end else begin
          uns_d[sk_rn] = 1'b1; j_d = j_q + 1'b1; ph_d = 2'd0;
        end
      end
      StEmit: begin
        if (i_q >= cnt) begin
          if (!any_q) begin
            strobe_d = 1'b1; res_d = '{safe_node: '0, valid_res: 1'b0, last: 1'b1};
          end
          st_d = StIdle;
        end else begin
          i_d = i_q + 1'b1;
          if (!uns_q[i_q[NodeW-1:0]]) begin
            // Hold the item until the next safe node or the end shows whether it is last.
            res_d = '{safe_node: i_q[NodeW-1:0], valid_res: 1'b1, last: 1'b0};
            any_d = 1'b1;
            st_d = StNone;
          end
        end
      end
      StNone: begin
        // Pending safe node in res_q; find the next one before releasing it.
        if (i_q >= cnt) begin
          strobe_d = 1'b1; res_d = res_q; res_d.last = 1'b1; st_d = StIdle;
        end else begin
          i_d = i_q + 1'b1;
          if (!uns_q[i_q[NodeW-1:0]]) begin
            strobe_d = 1'b1; res_d = res_q;
            st_d = StEmit; i_d = i_q;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  // StNone strobes the pending item held in res_q; StEmit then loads the next one into res_q.
  assign res_strobe_o = strobe_q;
  assign res_item_o   = res_q;
endmodule
